FILE: hw/rtl/b2dt_pkg.sv
// package for the decimal text formatter: widths, character codes, control structs
`timescale 1ns / 1ps

package b2dt_pkg;

    // fixed field widths
    localparam int VALUE_W       = 32;
    localparam int FIELD_W       = 5;
    localparam int CHAR_W        = 8;

    // decimal digits needed for a 32-bit value, four bits each
    localparam int BCD_DIGITS    = 10;
    localparam int NIBBLE_W      = 4;
    localparam int BCD_W         = BCD_DIGITS * NIBBLE_W;
    localparam int BCD_IDX_W     = $clog2(BCD_DIGITS);

    // one shift/adjust step per value bit
    localparam int SHIFT_STEPS   = VALUE_W;
    localparam int SHIFT_CNT_W   = $clog2(SHIFT_STEPS);

    // default field limit
    localparam int MAX_WIDTH_DEF = 16;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic calc;
        logic emit;
    } t_b2dt_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic width_zero;
        logic emit_last;
    } t_b2dt_sts;

endpackage

FILE: hw/rtl/b2dt_ctrl.sv
// controller for the decimal text formatter: sequences conversion and character output
`timescale 1ns / 1ps

module b2dt_ctrl
    import b2dt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_b2dt_sts i_sts,
    output t_b2dt_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [SHIFT_CNT_W-1:0] r_cnt;
    logic [SHIFT_CNT_W-1:0] n_cnt;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_cnt       = r_cnt + 1'b1;
                if (r_cnt == SHIFT_CNT_W'(SHIFT_STEPS - 1)) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_sts.width_zero ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

FILE: hw/rtl/b2dt_datapath.sv
// datapath for the decimal text formatter: shift-and-add-3 conversion and character select
`timescale 1ns / 1ps

module b2dt_datapath
    import b2dt_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_b2dt_cmd          i_cmd,
    output t_b2dt_sts          o_sts,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [FIELD_W-1:0] i_field_width,
    input  logic [FIELD_W-1:0] i_min_digits,
    input  logic               i_align_left,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_character,
    output logic [FIELD_W-1:0] o_digit_count,
    output logic               o_is_last
);

    // field limit, capped at what the width field can express
    localparam int FIELD_MAX = (1 << FIELD_W) - 1;
    localparam int CLAMP_INT = (MAX_WIDTH > FIELD_MAX) ? FIELD_MAX : MAX_WIDTH;
    localparam logic [FIELD_W-1:0] CLAMP = FIELD_W'(CLAMP_INT);

    logic [VALUE_W-1:0]                       r_bin;
    logic [BCD_DIGITS-1:0][NIBBLE_W-1:0]      r_bcd;
    logic [FIELD_W-1:0]                       r_width;
    logic [FIELD_W-1:0]                       r_min;
    logic                                     r_left;
    logic [FIELD_W-1:0]                       r_digits;
    logic [FIELD_W-1:0]                       r_idx;
    logic                                     r_valid;
    logic [CHAR_W-1:0]                        r_char;
    logic [FIELD_W-1:0]                       r_count;
    logic                                     r_last;

    logic [BCD_DIGITS-1:0][NIBBLE_W-1:0]      adj;
    logic [BCD_W+VALUE_W-1:0]                 shifted;
    logic [FIELD_W-1:0]                       nsig;
    logic [FIELD_W-1:0]                       eff;
    logic [FIELD_W-1:0]                       n_digits;
    logic [FIELD_W-1:0]                       rpos;
    logic [FIELD_W-1:0]                       lpos;
    logic [FIELD_W-1:0]                       pos;
    logic                                     is_digit;
    logic [NIBBLE_W-1:0]                      digit;
    logic [CHAR_W-1:0]                        n_char;

    // add 3 to every digit of 5 or more, then shift one value bit in
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= NIBBLE_W'(5)) ? r_bcd[i] + NIBBLE_W'(3) : r_bcd[i];
        end
        shifted = {adj, r_bin} << 1;
    end

    // significant digit count and digits shown in the field
    always_comb begin
        nsig = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[i] != '0) begin
                nsig = FIELD_W'(i + 1);
            end
        end
        eff      = (nsig > r_min) ? nsig : r_min;
        n_digits = (eff > r_width) ? r_width : eff;
    end

    // character for the current output position
    always_comb begin
        rpos     = r_width - FIELD_W'(1) - r_idx;
        lpos     = r_digits - FIELD_W'(1) - r_idx;
        is_digit = r_left ? (r_idx < r_digits) : (rpos < r_digits);
        pos      = r_left ? lpos : rpos;
        digit    = (pos < FIELD_W'(BCD_DIGITS)) ? r_bcd[pos[BCD_IDX_W-1:0]] : '0;
        n_char   = is_digit ? (CHAR_ZERO + CHAR_W'(digit)) : CHAR_SPACE;
    end

    assign o_sts.width_zero = (r_width == '0);
    assign o_sts.emit_last  = (r_idx == r_width - FIELD_W'(1));

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin   <= i_value;
            r_bcd   <= '0;
            r_width <= (i_field_width > CLAMP) ? CLAMP : i_field_width;
            r_min   <= i_min_digits;
            r_left  <= i_align_left;
            r_idx   <= '0;
        end else if (i_cmd.shift) begin
            {r_bcd, r_bin} <= shifted;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + FIELD_W'(1);
        end
        if (i_cmd.calc) begin
            r_digits <= n_digits;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_char  <= n_char;
            r_count <= r_digits;
            r_last  <= o_sts.emit_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_character   = r_char;
    assign o_digit_count = r_count;
    assign o_is_last     = r_last;

endmodule

FILE: hw/rtl/binary_to_decimal_text.sv
// top level of the decimal text formatter: controller and datapath
// the first character strobe comes from the emit step through the output register, after the
// load, shift/adjust and count steps, then one character per cycle; an item holds busy for
// 32 shift/adjust steps, one count step and one emit step per character, and a new item can start only once busy drops
// a zero field width produces no characters and ends busy after the count step
// reset clears the controller and the result strobe; the receiver cannot stall
`timescale 1ns / 1ps

module binary_to_decimal_text
    import b2dt_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [FIELD_W-1:0] i_field_width,
    input  logic [FIELD_W-1:0] i_min_digits,
    input  logic               i_align_left,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_character,
    output logic [FIELD_W-1:0] o_digit_count,
    output logic               o_is_last
);

    t_b2dt_cmd cmd;
    t_b2dt_sts sts;

    // sequencing
    b2dt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // conversion and output
    b2dt_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_value       (i_value),
        .i_field_width (i_field_width),
        .i_min_digits  (i_min_digits),
        .i_align_left  (i_align_left),
        .o_valid       (o_valid),
        .o_character   (o_character),
        .o_digit_count (o_digit_count),
        .o_is_last     (o_is_last)
    );

endmodule
